// ===== src/agt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agt_pkg
// Shared types, constants and helpers of the adaptive Gaussian threshold core.
// ----------------------------------------------------------------------------
package agt_pkg;

    localparam int AGT_MAX_WIDTH  = 1024;
    localparam int AGT_MAX_RADIUS = 3;
    localparam int AGT_MAX_HEIGHT = 4096;
    localparam int AGT_PIX_W      = 8;
    localparam int AGT_WGT_W      = 17;
    localparam int AGT_IW_W       = 11;
    localparam int AGT_IH_W       = 13;
    localparam int AGT_ROW_W      = 12;
    localparam int AGT_CFG_IDX_W  = 3;
    localparam int AGT_CFG_DATA_W = 17;

    // widths of the blur sums at the default radius
    localparam int AGT_DEF_DATA_W = $clog2(255 * 65536 * (2 * AGT_MAX_RADIUS + 1) + 1);
    localparam int AGT_DEF_ACC_W  = AGT_DEF_DATA_W + AGT_WGT_W
                                    + $clog2(2 * AGT_MAX_RADIUS + 1);

    typedef enum logic [AGT_CFG_IDX_W-1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_W_CENTER,
        REG_W_ONE,
        REG_W_TWO,
        REG_W_THREE,
        REG_OFFSET,
        REG_HIGH
    } t_cfg_reg;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    // weight of the tap at a given distance; zero beyond distance three
    function automatic logic [AGT_WGT_W-1:0] tap_weight(
        input int                   tap_dist,
        input logic [AGT_WGT_W-1:0] wc,
        input logic [AGT_WGT_W-1:0] w1,
        input logic [AGT_WGT_W-1:0] w2,
        input logic [AGT_WGT_W-1:0] w3
    );
        logic [AGT_WGT_W-1:0] w;
        case (tap_dist)
            0:       w = wc;
            1:       w = w1;
            2:       w = w2;
            3:       w = w3;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== src/adaptive_gaussian_threshold_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_gaussian_threshold_core
// Streaming adaptive Gaussian threshold over a raster of grayscale pixels.
// ----------------------------------------------------------------------------
// One word at a time. A pixel finishes J horizontal taps (0, 1, or up to R+1
// at a row end), each through the one shared MAC and the source ring read
// port. A pixel or drain word that yields a result then runs the vertical
// pass on the same MAC. Results lag R rows plus R columns. Reset clears
// control and loads the default configuration; the line rings are not
// cleared and need no clearing pass.
module adaptive_gaussian_threshold_core
    import agt_pkg::*;
#(
    parameter int MAX_WIDTH  = AGT_MAX_WIDTH,
    parameter int MAX_RADIUS = AGT_MAX_RADIUS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,  // pixel
    input  wire logic                      s_axis_tuser,  // mode
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [7:0]                m_axis_tdata,  // binary_value
    output logic                           m_axis_tlast,
    input  wire logic                      i_cfg_we,
    input  wire logic [AGT_CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [AGT_CFG_DATA_W-1:0] i_cfg_data
);

    localparam int R         = MAX_RADIUS;
    localparam int NTAP      = 2 * R + 1;
    localparam int TW        = $clog2(NTAP);
    localparam int SRC_DEPTH = (R + 1) * MAX_WIDTH;
    localparam int HB_DEPTH  = NTAP * MAX_WIDTH;
    localparam int SAW       = $clog2(SRC_DEPTH);
    localparam int HAW       = $clog2(HB_DEPTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int CLW       = $clog2(MAX_WIDTH);
    localparam int PW        = $clog2(MAX_WIDTH * AGT_MAX_HEIGHT + 1);
    localparam int HBW       = $clog2(255 * 65536 * NTAP + 1);
    localparam int VW        = HBW + AGT_WGT_W + $clog2(NTAP);
    localparam int CMPW      = VW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_HTAP, S_HWAIT, S_POST, S_ESRC, S_ESRC2, S_VTAP, S_VWAIT, S_OUT
    } t_state;

    t_state r_state;

    logic [AGT_IW_W-1:0]         r_image_width;
    logic [AGT_IH_W-1:0]         r_image_height;
    logic [AGT_WGT_W-1:0]        r_wc, r_w1, r_w2, r_w3;
    logic signed [AGT_WGT_W-1:0] r_offset;
    logic [7:0]                  r_high;

    logic [CLW-1:0]       r_col, r_hk, r_he, r_ox;
    logic [AGT_ROW_W-1:0] r_row, r_oy;
    logic [PW-1:0]        r_in_pos, r_out_pos;
    logic [SAW-1:0]       r_src_base, r_osrc_base;
    logic [HAW-1:0]       r_hb_base, r_ohb_base;
    logic                 r_frame_full;
    logic [7:0]           r_pix, r_opix;
    logic [TW-1:0]        r_tap;
    t_mac_ctl             r_tap_ctl;
    logic [AGT_WGT_W-1:0] r_tap_w;
    logic                 r_tap_sel;
    logic                 r_out_valid, r_out_last;
    logic [7:0]           r_out_data;

    logic [7:0]     src_mem [SRC_DEPTH];
    logic [HBW-1:0] hb_mem  [HB_DEPTH];
    logic [7:0]     r_src_rd;
    logic [HBW-1:0] r_hb_rd;

    logic [WW-1:0]       eff_w;
    logic [AGT_IH_W-1:0] eff_h;
    logic [PW-1:0]       wh, lag;
    logic [SAW-1:0]      src_raddr, src_waddr, n_src_base, n_osrc_base;
    logic [HAW-1:0]      hb_raddr, hb_waddr, n_hb_base, n_ohb_base;
    logic [AGT_WGT_W-1:0] cur_w;
    logic                src_we, hb_we, do_restart, above, mac_done, row_end;
    logic [VW-1:0]       mac_acc;
    logic signed [CMPW-1:0] lhs, rhs;

    always_comb begin
        int iw, ih, d, c, a, rr, s;
        iw = int'(r_image_width);
        if (iw < 1) iw = 1;
        if (iw > MAX_WIDTH) iw = MAX_WIDTH;
        ih = int'(r_image_height);
        if (ih < 1) ih = 1;
        if (ih > AGT_MAX_HEIGHT) ih = AGT_MAX_HEIGHT;
        eff_w = WW'(iw);
        eff_h = AGT_IH_W'(ih);
        wh    = PW'(iw * ih);
        lag   = PW'(R * iw + R);
        d     = int'(r_tap) - R;
        cur_w = tap_weight((d < 0) ? -d : d, r_wc, r_w1, r_w2, r_w3);

        c = int'(r_hk) + d;
        if (c < 0) c = 0;
        if (c > iw - 1) c = iw - 1;
        a = int'(r_src_base) + c;
        if (a >= SRC_DEPTH) a = a - SRC_DEPTH;
        if (r_state == S_ESRC) begin
            a = int'(r_osrc_base) + int'(r_ox);
            if (a >= SRC_DEPTH) a = a - SRC_DEPTH;
        end
        src_raddr = SAW'(a);

        rr = int'(r_oy) + d;
        if (rr < 0) rr = 0;
        if (rr > ih - 1) rr = ih - 1;
        s = int'(r_ohb_base) + int'(r_ox) + (rr - int'(r_oy)) * iw;
        if (s < 0) s = s + HB_DEPTH;
        else if (s >= HB_DEPTH) s = s - HB_DEPTH;
        hb_raddr = HAW'(s);

        a = int'(r_src_base) + int'(r_col);
        if (a >= SRC_DEPTH) a = a - SRC_DEPTH;
        src_waddr = SAW'(a);
        a = int'(r_hb_base) + int'(r_hk);
        if (a >= HB_DEPTH) a = a - HB_DEPTH;
        hb_waddr = HAW'(a);

        a = int'(r_src_base) + iw;
        if (a >= SRC_DEPTH) a = a - SRC_DEPTH;
        n_src_base = SAW'(a);
        a = int'(r_hb_base) + iw;
        if (a >= HB_DEPTH) a = a - HB_DEPTH;
        n_hb_base = HAW'(a);
        a = int'(r_osrc_base) + iw;
        if (a >= SRC_DEPTH) a = a - SRC_DEPTH;
        n_osrc_base = SAW'(a);
        a = int'(r_ohb_base) + iw;
        if (a >= HB_DEPTH) a = a - HB_DEPTH;
        n_ohb_base = HAW'(a);
    end

    assign row_end = (int'(r_col) == int'(eff_w) - 1);
    assign src_we  = (r_state == S_WR);
    assign hb_we   = (r_state == S_HWAIT) && mac_done;
    assign lhs = $signed({{(CMPW-40){1'b0}}, r_opix, 32'd0})
               + $signed({{(CMPW-41){r_offset[AGT_WGT_W-1]}}, r_offset, 24'd0});
    assign rhs   = $signed({2'b00, mac_acc});
    assign above = lhs > rhs;
    assign do_restart = (i_cfg_we && (t_cfg_reg'(i_cfg_idx) == REG_WIDTH
                                   || t_cfg_reg'(i_cfg_idx) == REG_HEIGHT))
                     || (r_state == S_IDLE && s_axis_tvalid && !s_axis_tuser
                         && (r_frame_full || int'(r_col) >= int'(eff_w)
                             || int'(r_row) >= int'(eff_h)));

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            src_mem[src_waddr] <= r_pix;
        end
        r_src_rd <= src_mem[src_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (hb_we) begin
            hb_mem[hb_waddr] <= HBW'(mac_acc);
        end
        r_hb_rd <= hb_mem[hb_raddr];
    end

    agt_mac #(
        .DATA_W (HBW),
        .ACC_W  (VW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_tap_ctl),
        .i_weight (r_tap_w),
        .i_data   (r_tap_sel ? r_hb_rd : HBW'(r_src_rd)),
        .o_acc    (mac_acc),
        .o_done   (mac_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_image_width  <= AGT_IW_W'(1024);
            r_image_height <= AGT_IH_W'(480);
            r_wc           <= AGT_WGT_W'(65536);
            r_w1           <= '0;
            r_w2           <= '0;
            r_w3           <= '0;
            r_offset       <= '0;
            r_high         <= 8'd255;
            r_col          <= '0;
            r_row          <= '0;
            r_in_pos       <= '0;
            r_src_base     <= '0;
            r_hb_base      <= '0;
            r_out_pos      <= '0;
            r_ox           <= '0;
            r_oy           <= '0;
            r_osrc_base    <= '0;
            r_ohb_base     <= '0;
            r_frame_full   <= 1'b0;
            r_hk           <= '0;
            r_he           <= '0;
            r_tap          <= '0;
            r_tap_ctl      <= '0;
            r_tap_w        <= '0;
            r_tap_sel      <= 1'b0;
            r_pix          <= '0;
            r_opix         <= '0;
            r_out_valid    <= 1'b0;
            r_out_last     <= 1'b0;
            r_out_data     <= '0;
        end else begin
            r_tap_ctl <= '0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser) begin
                            if (r_frame_full && r_out_pos < wh) begin
                                r_state <= S_ESRC;
                            end
                        end else begin
                            r_pix   <= s_axis_tdata;
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    r_tap <= '0;
                    r_hk  <= (int'(r_col) >= R) ? CLW'(int'(r_col) - R) : '0;
                    r_he  <= row_end ? CLW'(int'(eff_w) - 1) : CLW'(int'(r_col) - R);
                    r_state <= (int'(r_col) >= R || row_end) ? S_HTAP : S_POST;
                end
                S_HTAP, S_VTAP: begin
                    r_tap_ctl <= '{valid: 1'b1, first: (r_tap == '0),
                                   last: (int'(r_tap) == NTAP - 1)};
                    r_tap_w   <= cur_w;
                    r_tap_sel <= (r_state == S_VTAP);
                    if (int'(r_tap) == NTAP - 1) begin
                        r_tap   <= '0;
                        r_state <= (r_state == S_VTAP) ? S_VWAIT : S_HWAIT;
                    end else begin
                        r_tap <= r_tap + 1'b1;
                    end
                end
                S_HWAIT: begin
                    if (mac_done) begin
                        if (r_hk == r_he) begin
                            r_state <= S_POST;
                        end else begin
                            r_hk    <= r_hk + 1'b1;
                            r_state <= S_HTAP;
                        end
                    end
                end
                S_POST: begin
                    r_state <= ({1'b0, r_out_pos} + {1'b0, lag} < {1'b0, r_in_pos} + 1'b1)
                               ? S_ESRC : S_IDLE;
                    if (row_end) begin
                        r_col <= '0;
                        if (int'(r_row) == int'(eff_h) - 1) begin
                            r_row        <= '0;
                            r_in_pos     <= '0;
                            r_src_base   <= '0;
                            r_hb_base    <= '0;
                            r_frame_full <= 1'b1;
                        end else begin
                            r_row      <= r_row + 1'b1;
                            r_in_pos   <= r_in_pos + 1'b1;
                            r_src_base <= n_src_base;
                            r_hb_base  <= n_hb_base;
                        end
                    end else begin
                        r_col    <= r_col + 1'b1;
                        r_in_pos <= r_in_pos + 1'b1;
                    end
                end
                S_ESRC: begin
                    r_state <= S_ESRC2;
                end
                S_ESRC2: begin
                    r_opix  <= r_src_rd;
                    r_tap   <= '0;
                    r_state <= S_VTAP;
                end
                S_VWAIT: begin
                    if (mac_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= above ? r_high : 8'd0;
                        r_out_last  <= (r_out_pos + 1'b1 == wh);
                        r_out_pos   <= r_out_pos + 1'b1;
                        if (int'(r_ox) == int'(eff_w) - 1) begin
                            r_ox        <= '0;
                            r_oy        <= r_oy + 1'b1;
                            r_osrc_base <= n_osrc_base;
                            r_ohb_base  <= n_ohb_base;
                        end else begin
                            r_ox <= r_ox + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_WIDTH:    r_image_width  <= i_cfg_data[AGT_IW_W-1:0];
                    REG_HEIGHT:   r_image_height <= i_cfg_data[AGT_IH_W-1:0];
                    REG_W_CENTER: r_wc           <= i_cfg_data;
                    REG_W_ONE:    r_w1           <= i_cfg_data;
                    REG_W_TWO:    r_w2           <= i_cfg_data;
                    REG_W_THREE:  r_w3           <= i_cfg_data;
                    REG_OFFSET:   r_offset       <= $signed(i_cfg_data);
                    REG_HIGH:     r_high         <= i_cfg_data[7:0];
                    default:      ;
                endcase
            end

            if (do_restart) begin
                r_col        <= '0;
                r_row        <= '0;
                r_in_pos     <= '0;
                r_src_base   <= '0;
                r_hb_base    <= '0;
                r_out_pos    <= '0;
                r_ox         <= '0;
                r_oy         <= '0;
                r_osrc_base  <= '0;
                r_ohb_base   <= '0;
                r_frame_full <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_idle_no_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_tap_ctl.valid)
        else $error("tap in flight while idle");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_HWAIT || r_state == S_VWAIT))
        else $error("MAC result outside a wait state");
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || m_axis_tready)) |=> r_out_valid)
        else $error("result word not loaded");
    a_full_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_full |-> (r_col == '0 && r_row == '0))
        else $error("input position not at origin after frame end");
`endif

endmodule
`default_nettype wire

// ===== src/agt_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agt_mac
// Two-stage multiply-accumulate shared by the horizontal and vertical passes.
// ----------------------------------------------------------------------------
module agt_mac
    import agt_pkg::*;
#(
    parameter int DATA_W = AGT_DEF_DATA_W,
    parameter int ACC_W  = AGT_DEF_ACC_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_mac_ctl             i_ctl,
    input  wire logic [AGT_WGT_W-1:0] i_weight,
    input  wire logic [DATA_W-1:0]    i_data,
    output logic      [ACC_W-1:0]     o_acc,
    output logic                      o_done
);

    localparam int PROD_W = AGT_WGT_W + DATA_W;

    t_mac_ctl          r_s1;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= '0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_ctl;
            r_done <= r_s1.valid && r_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_weight) * PROD_W'(i_data);
        if (r_s1.valid) begin
            r_acc <= (r_s1.first ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== tb/adaptive_gaussian_threshold_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_gaussian_threshold_checker
// Watches the pixel, result and register channels of the threshold core.
// Keeps its own line stores, positions and registers, works out the binary
// word owed whenever an accepted pixel or drain word yields one and compares
// each accepted result word against the oldest one owed.
// ----------------------------------------------------------------------------
module adaptive_gaussian_threshold_checker
    import agt_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_ready,
    input  wire logic [7:0]                i_in_pixel,
    input  wire logic                      i_in_mode,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic [7:0]                i_out_value,
    input  wire logic                      i_out_last,
    input  wire logic                      i_cfg_we,
    input  wire logic [AGT_CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [AGT_CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    localparam int SRC_DEPTH = (AGT_MAX_RADIUS + 1) * AGT_MAX_WIDTH;
    localparam int HB_DEPTH  = (2 * AGT_MAX_RADIUS + 1) * AGT_MAX_WIDTH;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_binary_word;

    logic [7:0]            src_ring [0:SRC_DEPTH-1];
    logic [31:0]           hsum_ring [0:HB_DEPTH-1];
    int unsigned           in_col, in_row, out_pos;
    bit                    frame_done;
    logic [AGT_IW_W-1:0]   reg_w;
    logic [AGT_IH_W-1:0]   reg_h;
    logic [AGT_WGT_W-1:0]  tap_wgt [0:3];
    logic signed [16:0]    reg_offset;
    logic [7:0]            reg_high;
    t_binary_word          binary_q[$];

    assign o_pending = binary_q.size();

    function automatic int unsigned frame_w();
        if (reg_w < 1) return 1;
        if (reg_w > AGT_MAX_WIDTH) return AGT_MAX_WIDTH;
        return reg_w;
    endfunction

    function automatic int unsigned frame_h();
        if (reg_h < 1) return 1;
        if (reg_h > AGT_MAX_HEIGHT) return AGT_MAX_HEIGHT;
        return reg_h;
    endfunction

    function automatic logic [63:0] weight_at(int d);
        if (d < 0) d = -d;
        if (d <= 3) return 64'(tap_wgt[d]);
        return '0;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        in_col     = 0;
        in_row     = 0;
        out_pos    = 0;
        frame_done = 0;
    endfunction

    function automatic void row_blur(int unsigned r, int unsigned c, int unsigned w);
        logic [63:0] acc;
        int          k;
        acc = '0;
        for (int d = -AGT_MAX_RADIUS; d <= AGT_MAX_RADIUS; d++) begin
            k   = clamp(int'(c) + d, 0, int'(w) - 1);
            acc = acc + weight_at(d) * 64'(src_ring[(r * w + k) % SRC_DEPTH]);
        end
        hsum_ring[(r * w + c) % HB_DEPTH] = acc[31:0];
    endfunction

    function automatic void owe_binary(int unsigned w, int unsigned h);
        int unsigned  y, x, r;
        logic [63:0]  vsum;
        longint       lhs;
        t_binary_word bw;
        y    = out_pos / w;
        x    = out_pos % w;
        vsum = '0;
        for (int d = -AGT_MAX_RADIUS; d <= AGT_MAX_RADIUS; d++) begin
            r    = clamp(int'(y) + d, 0, int'(h) - 1);
            vsum = vsum + weight_at(d) * 64'(hsum_ring[(r * w + x) % HB_DEPTH]);
        end
        lhs = longint'(src_ring[out_pos % SRC_DEPTH]) * 64'sd4294967296
            + longint'(reg_offset) * 64'sd16777216;
        bw.value = (lhs > longint'(vsum)) ? reg_high : 8'd0;
        bw.last  = (out_pos + 1 == w * h);
        binary_q.push_back(bw);
        out_pos++;
    endfunction

    function automatic void take_word(logic mode, logic [7:0] pix);
        int unsigned w, h, lag, pos;
        w   = frame_w();
        h   = frame_h();
        lag = AGT_MAX_RADIUS * w + AGT_MAX_RADIUS;
        if (mode) begin
            if (frame_done && out_pos < w * h) owe_binary(w, h);
            return;
        end
        if (frame_done) restart_frame();
        if (in_col >= w || in_row >= h) restart_frame();
        pos = in_row * w + in_col;
        src_ring[pos % SRC_DEPTH] = pix;
        if (in_col >= AGT_MAX_RADIUS) row_blur(in_row, in_col - AGT_MAX_RADIUS, w);
        if (in_col == w - 1) begin
            for (int unsigned k = (w > AGT_MAX_RADIUS) ? w - AGT_MAX_RADIUS : 0; k < w; k++)
                row_blur(in_row, k, w);
        end
        in_col++;
        if (in_col == w) begin
            in_col = 0;
            in_row++;
            if (in_row == h) begin
                in_row     = 0;
                frame_done = 1;
            end
        end
        if (out_pos + lag < pos + 1) owe_binary(w, h);
    endfunction

    always @(posedge i_clk) begin
        t_binary_word bw;
        if (!i_rst_n) begin
            reg_w      <= AGT_IW_W'(1024);
            reg_h      <= AGT_IH_W'(480);
            tap_wgt[0] <= AGT_WGT_W'(65536);
            tap_wgt[1] <= '0;
            tap_wgt[2] <= '0;
            tap_wgt[3] <= '0;
            reg_offset <= '0;
            reg_high   <= 8'd255;
            in_col     <= 0;
            in_row     <= 0;
            out_pos    <= 0;
            frame_done <= 0;
            o_fail_count <= 0;
            o_checked    <= 0;
            binary_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked <= o_checked + 1;
                if (binary_q.size() == 0) begin
                    $error("unexpected result word: binary_value %0d last_of_frame %0d",
                           i_out_value, i_out_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    bw = binary_q.pop_front();
                    if (i_out_value !== bw.value || i_out_last !== bw.last)
                        o_fail_count <= o_fail_count + 1;
                    if (i_out_value !== bw.value)
                        $error("binary_value: expected %0d, got %0d", bw.value, i_out_value);
                    if (i_out_last !== bw.last)
                        $error("last_of_frame: expected %0d, got %0d", bw.last, i_out_last);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_WIDTH: begin
                        reg_w = i_cfg_data[AGT_IW_W-1:0];
                        restart_frame();
                    end
                    REG_HEIGHT: begin
                        reg_h = i_cfg_data[AGT_IH_W-1:0];
                        restart_frame();
                    end
                    REG_W_CENTER: tap_wgt[0] = i_cfg_data;
                    REG_W_ONE:    tap_wgt[1] = i_cfg_data;
                    REG_W_TWO:    tap_wgt[2] = i_cfg_data;
                    REG_W_THREE:  tap_wgt[3] = i_cfg_data;
                    REG_OFFSET:   reg_offset = i_cfg_data;
                    REG_HIGH:     reg_high   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_word(i_in_mode, i_in_pixel);
        end
    end

endmodule

// ===== tb/adaptive_gaussian_threshold_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_gaussian_threshold_core_test
// Stimulus and verdict for the adaptive Gaussian threshold core.
// Register settings first cover saturated sizes and extreme weights, offsets
// and high values, then random small frames with random drains, early new
// frames, split tails with register writes between them and random stalls on
// both sides. The checker beside the core predicts and compares each result.
// ----------------------------------------------------------------------------
module adaptive_gaussian_threshold_core_test;
    import agt_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PIXEL_GOAL  = 1900;

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      s_axis_tvalid = 0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = 0;
    logic                      s_axis_tuser = 0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 0;
    logic [7:0]                m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      i_cfg_we = 0;
    logic [AGT_CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [AGT_CFG_DATA_W-1:0] i_cfg_data = '0;

    int          fail_count, pending, checked;
    int          cycles = 0;
    int          pixels_sent = 0, drains_sent = 0, settings = 0;
    int unsigned cur_w = 1024, cur_h = 480;
    bit          calm_tx = 0, calm_rx = 0;
    int          rx_stall = 0;

    adaptive_gaussian_threshold_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    adaptive_gaussian_threshold_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_pixel(s_axis_tdata), .i_in_mode(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_value(m_axis_tdata), .i_out_last(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** adaptive_gaussian_threshold_core: FAILED **");
            $finish;
        end
    end

    function automatic int gap_len(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // result side: random stalls
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            m_axis_tready <= 0;
            rx_stall      <= rx_stall - 1;
        end else begin
            m_axis_tready <= 1;
            rx_stall      <= gap_len(calm_rx);
        end
    end

    task automatic push_word(logic mode, logic [7:0] pix);
        int g;
        g = gap_len(calm_tx);
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode) drains_sent++;
        else pixels_sent++;
    endtask

    // pause until nothing is owed and the core has had time to finish
    task automatic settle();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic reg_write(t_cfg_reg idx, logic [AGT_CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_WIDTH)
            cur_w = (val[10:0] == 0) ? 1 : (val[10:0] > AGT_MAX_WIDTH) ? AGT_MAX_WIDTH
                                                                         : val[10:0];
        if (idx == REG_HEIGHT)
            cur_h = (val[12:0] == 0) ? 1 : (val[12:0] > AGT_MAX_HEIGHT) ? AGT_MAX_HEIGHT
                                                                          : val[12:0];
    endtask

    task automatic setup(int w, int h, int wc, int w1, int w2, int w3, int offs, int hv);
        reg_write(REG_WIDTH, AGT_CFG_DATA_W'(w));
        reg_write(REG_HEIGHT, AGT_CFG_DATA_W'(h));
        reg_write(REG_W_CENTER, AGT_CFG_DATA_W'(wc));
        reg_write(REG_W_ONE, AGT_CFG_DATA_W'(w1));
        reg_write(REG_W_TWO, AGT_CFG_DATA_W'(w2));
        reg_write(REG_W_THREE, AGT_CFG_DATA_W'(w3));
        reg_write(REG_OFFSET, 17'(offs));
        reg_write(REG_HIGH, AGT_CFG_DATA_W'(hv));
        i_cfg_we <= 0;
        settings++;
    endtask

    function automatic int rand_offset();
        int r;
        r = $urandom_range(9);
        if (r == 0) return -65280;
        if (r == 1) return 65280;
        if (r < 5) return int'($urandom_range(130560)) - 65280;
        return int'($urandom_range(4096)) - 2048;
    endfunction

    // one frame of pixels with stray drains; tail flushed fully or in part
    task automatic run_frame(bit split_tail);
        int unsigned tail, n;
        for (int unsigned i = 0; i < cur_w * cur_h; i++) begin
            if ($urandom_range(9) == 0) push_word(1, 8'($urandom));
            push_word(0, 8'($urandom));
        end
        tail = (AGT_MAX_RADIUS * cur_w + AGT_MAX_RADIUS < cur_w * cur_h)
             ? AGT_MAX_RADIUS * cur_w + AGT_MAX_RADIUS : cur_w * cur_h;
        case ($urandom_range(5))
            0: n = $urandom_range(tail);
            1: n = tail + $urandom_range(3, 1);
            default: n = tail;
        endcase
        for (int unsigned i = 0; i < n; i++) begin
            // a register change while part of the tail is still owed
            if (split_tail && i == n / 2) begin
                settle();
                reg_write(REG_OFFSET, 17'(rand_offset()));
                reg_write(REG_HIGH, AGT_CFG_DATA_W'($urandom_range(255)));
                i_cfg_we <= 0;
            end
            push_word(1, 8'($urandom));
        end
    endtask

    initial begin
        int w, h, wc, frames;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // width and height of zero saturate to one pixel
        setup(0, 0, 65536, 65536, 65536, 65536, 65280, 0);
        push_word(1, 8'h00);
        push_word(0, 8'hFF);
        push_word(1, 8'h00);
        push_word(1, 8'hFF);
        push_word(0, 8'h00);
        push_word(0, 8'h07);
        push_word(1, 8'h00);
        settle();

        // oversized height, abandoned by the next size write
        setup(1, 8191, 0, 0, 0, 0, -65280, 255);
        for (int i = 0; i < 14; i++) begin
            if (i == 8) settle();
            push_word(0, (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'($urandom));
        end
        settle();

        // oversized width saturates to the widest row
        setup(2047, 1, 16384, 12288, 6144, 2048, 0, 200);
        run_frame(0);
        settle();

        while (pixels_sent < PIXEL_GOAL) begin
            calm_tx = ($urandom_range(4) == 0);
            calm_rx = ($urandom_range(4) == 0);
            w  = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
            h  = ($urandom_range(7) == 0) ? $urandom_range(10, 1) : $urandom_range(6, 1);
            wc = $urandom_range(65536);
            if ($urandom_range(5) == 0)
                setup(w, h, wc, $urandom_range(65536), $urandom_range(65536),
                      $urandom_range(65536), rand_offset(), $urandom_range(255));
            else
                setup(w, h, wc, $urandom_range(65536 - wc) / 2,
                      $urandom_range(16384), $urandom_range(8192), rand_offset(),
                      $urandom_range(255));
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++) run_frame($urandom_range(5) == 0);
            // now and then leave a frame unfinished before the next size write
            if ($urandom_range(5) == 0)
                for (int i = $urandom_range(w * h); i > 0; i--) push_word(0, 8'($urandom));
            settle();
        end

        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d register settings, %0d pixels and %0d drain words",
                 settings, pixels_sent, drains_sent);
        $display("%0d result words compared", checked);
        if (fail_count == 0)
            $display("** adaptive_gaussian_threshold_core: PASSED **");
        else
            $display("** adaptive_gaussian_threshold_core: FAILED **");
        $finish;
    end

endmodule
